FILE: src/blv_pkg.sv
// Shared types and constants for the battery level gauge.
`default_nettype none
package blv_pkg;

    localparam int VOLT_W  = 12;
    localparam int LEVEL_W = 8;
    localparam int RISE_W  = 8;
    localparam int PTS_W   = 10;
    localparam int CFG_W   = 12;

    // default discharge curve, level 100 - 20*m at point m
    localparam logic [VOLT_W-1:0] DFLT_CURVE [6] = '{
        12'd2080, 12'd2000, 12'd1932, 12'd1888, 12'd1852, 12'd1603
    };
    localparam int DFLT_K = 5;

    localparam logic [VOLT_W-1:0] RST_MIN_VALID = 12'd1000;
    localparam logic [RISE_W-1:0] RST_RISE      = 8'd2;
    localparam logic [PTS_W-1:0]  RST_MIN_PTS   = 10'd5;
    localparam logic [PTS_W-1:0]  MIN_PTS_FLOOR = 10'd3;

    localparam logic signed [LEVEL_W-1:0] LEVEL_FULL    = 8'sd100;
    localparam logic signed [LEVEL_W-1:0] LEVEL_EMPTY   = 8'sd0;
    localparam logic signed [LEVEL_W-1:0] LEVEL_INVALID = -8'sd1;
    localparam logic [6:0] LEVEL_SCALE = 7'd100;

    typedef enum logic [1:0] {
        CFG_LEARN_MODE = 2'd0,
        CFG_MIN_VALID  = 2'd1,
        CFG_RISE       = 2'd2,
        CFG_MIN_PTS    = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_EVAL,
        OP_C1,
        OP_CN,
        OP_SCAN,
        OP_RUN,
        OP_M1,
        OP_M2,
        OP_M3,
        OP_DIV,
        OP_NEXT,
        OP_APPEND
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic ev_done;
        logic ev_arith;
        logic hit_hi;
        logic hit_lo;
        logic scan_hit;
        logic scan_end;
        logic run_more;
        logic zero;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

FILE: src/blv_intf.sv
// Channel interfaces: sample input, result output and register write.
`default_nettype none
interface blv_in_if import blv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [VOLT_W-1:0] voltage_mv;
    modport source (output valid, output voltage_mv, input ready);
    modport sink   (input valid, input voltage_mv, output ready);
endinterface

interface blv_out_if import blv_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [LEVEL_W-1:0] level_percent;
    logic                      level_changed;
    logic                      charging;
    logic [PTS_W-1:0]          learned_points;
    logic                      learn_dropped;
    modport source (output valid, output level_percent, output level_changed,
                    output charging, output learned_points, output learn_dropped,
                    input ready);
    modport sink   (input valid, input level_percent, input level_changed,
                    input charging, input learned_points, input learn_dropped,
                    output ready);
endinterface

interface blv_cfg_if import blv_pkg::*; ();
    logic             valid;
    logic             ready;
    t_cfg_idx         index;
    logic [CFG_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: src/blv_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module blv_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: src/blv_ctrl.sv
// Sequencer that steps the datapath through one sample.
`default_nettype none
module blv_ctrl import blv_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_C1, S_CN, S_SCAN, S_RUN,
        S_M1, S_M2, S_M3, S_DIV, S_NEXT, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_sel, n_sel;   // 0: level of previous sample, 1: of new sample
    t_state s_done;

    assign o_in_ready = (r_state == S_IDLE);
    assign s_done     = r_sel ? S_FIN : S_NEXT;

    always_comb begin
        n_state  = r_state;
        n_sel    = r_sel;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_START;
                    n_sel    = 1'b0;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.op = OP_EVAL;
                priority if (i_stat.ev_done) n_state = s_done;
                else if (i_stat.ev_arith)    n_state = S_M1;
                else                         n_state = S_C1;
            end
            S_C1: begin
                o_cmd.op = OP_C1;
                n_state  = i_stat.hit_hi ? s_done : S_CN;
            end
            S_CN: begin
                o_cmd.op = OP_CN;
                n_state  = i_stat.hit_lo ? s_done : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN;
                priority if (i_stat.scan_hit) n_state = S_RUN;
                else if (i_stat.scan_end)     n_state = s_done;
                else                          n_state = S_SCAN;
            end
            S_RUN: begin
                o_cmd.op = OP_RUN;
                if (!i_stat.run_more) begin
                    n_state = S_M1;
                end
            end
            S_M1: begin
                o_cmd.op = OP_M1;
                n_state  = S_M2;
            end
            S_M2: begin
                o_cmd.op = OP_M2;
                n_state  = i_stat.zero ? s_done : S_M3;
            end
            S_M3: begin
                o_cmd.op = OP_M3;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_stat.div_last) begin
                    n_state = s_done;
                end
            end
            S_NEXT: begin
                o_cmd.op = OP_NEXT;
                n_sel    = 1'b1;
                n_state  = S_EVAL;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_APPEND;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end
endmodule
`default_nettype wire

FILE: src/blv_dp.sv
// Datapath: registers, history, learned curve RAM, interpolation and divider.
`default_nettype none
module blv_dp import blv_pkg::*; #(
    parameter int CURVE_DEPTH = 512
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_cmd                      i_cmd,
    output t_stat                          o_stat,
    input  wire logic [VOLT_W-1:0]         i_voltage,
    input  wire logic                      i_cfg_we,
    input  wire t_cfg_idx                  i_cfg_idx,
    input  wire logic [CFG_W-1:0]          i_cfg_data,
    input  wire logic                      i_out_ready,
    output logic                           o_out_valid,
    output logic signed [LEVEL_W-1:0]      o_level,
    output logic                           o_changed,
    output logic                           o_charging,
    output logic [PTS_W-1:0]               o_points,
    output logic                           o_dropped
);
    localparam int AW = $clog2(CURVE_DEPTH);
    localparam int CW = $clog2(CURVE_DEPTH + 1);
    localparam int LW = (CW > PTS_W) ? CW : PTS_W;
    localparam int PW = CW + VOLT_W;
    localparam int NW = PW + 7;
    localparam logic [CW-1:0] DEPTH_C = CW'(CURVE_DEPTH);

    // configuration
    logic              r_learn, n_learn;
    logic [VOLT_W-1:0] r_min_valid, n_min_valid;
    logic [RISE_W-1:0] r_rise, n_rise;
    logic [PTS_W-1:0]  r_min_pts, n_min_pts;
    // persistent state
    logic              r_seen, n_seen;
    logic [VOLT_W-1:0] r_latest, n_latest, r_prev, n_prev, r_older, n_older;
    logic [CW-1:0]     r_count, n_count;
    logic [VOLT_W-1:0] r_last, n_last;
    // per-sample work registers
    logic [VOLT_W-1:0] r_v, n_v, r_x, n_x;
    logic              r_charging, n_charging;
    logic signed [LEVEL_W-1:0] r_level, n_level, r_before, n_before;
    logic [CW-1:0]     r_k, n_k, r_j, n_j, r_len, n_len, r_i, n_i;
    logic [VOLT_W-1:0] r_pre, n_pre, r_aft, n_aft;
    logic              r_flat, n_flat;
    logic [PW-1:0]     r_whole, n_whole, r_part, n_part, r_den, n_den;
    logic [NW-1:0]     r_rem, n_rem;
    logic [2:0]        r_b, n_b;
    // output register
    logic              r_out_valid, n_out_valid;
    logic signed [LEVEL_W-1:0] r_o_level, n_o_level;
    logic              r_o_changed, n_o_changed, r_o_charging, n_o_charging;
    logic [PTS_W-1:0]  r_o_points, n_o_points;
    logic              r_o_dropped, n_o_dropped;

    // RAM
    logic              s_we;
    logic [AW-1:0]     s_waddr, s_raddr;
    logic [VOLT_W-1:0] s_wdata, s_rd;

    logic [PTS_W-1:0]  s_thr;
    logic              s_use_dflt, s_lt_min;
    logic [CW-1:0]     s_dj;
    logic [VOLT_W-1:0] s_dpre, s_daft, s_span, s_app;
    logic [CW-1:0]     s_kj;
    logic [VOLT_W:0]   s_sum_p, s_sum_o;
    logic [NW-1:0]     s_shift;

    blv_ram #(.WIDTH(VOLT_W), .DEPTH(CURVE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_waddr),
        .i_wdata(s_wdata),
        .i_raddr(s_raddr),
        .o_rdata(s_rd)
    );

    assign s_thr      = (r_min_pts < MIN_PTS_FLOOR) ? MIN_PTS_FLOOR : r_min_pts;
    assign s_use_dflt = r_learn || (LW'(r_count) <= LW'(s_thr));
    assign s_lt_min   = r_x < r_min_valid;
    assign s_span     = r_pre - r_aft;
    assign s_kj       = r_k - r_j;
    assign s_shift    = NW'(r_den) << r_b;

    // first default point at or below x
    always_comb begin
        s_dj   = '0;
        s_dpre = DFLT_CURVE[0];
        s_daft = DFLT_CURVE[1];
        for (int m = DFLT_K; m >= 1; m--) begin
            if (r_x >= DFLT_CURVE[m]) begin
                s_dj   = CW'(m - 1);
                s_dpre = DFLT_CURVE[m-1];
                s_daft = DFLT_CURVE[m];
            end
        end
    end

    always_comb begin
        o_stat.ev_done  = s_lt_min ||
                          (s_use_dflt && (r_x >= DFLT_CURVE[0] || r_x <= DFLT_CURVE[DFLT_K]));
        o_stat.ev_arith = !o_stat.ev_done && s_use_dflt;
        o_stat.hit_hi   = r_x >= s_rd;
        o_stat.hit_lo   = r_x <= s_rd;
        o_stat.scan_hit = r_x >= s_rd;
        o_stat.scan_end = (r_i + CW'(1)) >= (r_count - CW'(1));
        o_stat.run_more = ((r_i + CW'(1)) < (r_count - CW'(1))) && (s_rd >= r_aft);
        o_stat.zero     = r_part >= r_whole;
        o_stat.div_last = (r_b == 3'd0);
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_learn = r_learn;   n_min_valid = r_min_valid;
        n_rise  = r_rise;    n_min_pts   = r_min_pts;
        n_seen  = r_seen;    n_latest = r_latest; n_prev = r_prev; n_older = r_older;
        n_count = r_count;   n_last = r_last;
        n_v = r_v; n_x = r_x; n_charging = r_charging;
        n_level = r_level; n_before = r_before;
        n_k = r_k; n_j = r_j; n_len = r_len; n_i = r_i;
        n_pre = r_pre; n_aft = r_aft; n_flat = r_flat;
        n_whole = r_whole; n_part = r_part; n_den = r_den;
        n_rem = r_rem; n_b = r_b;
        n_out_valid  = r_out_valid;
        n_o_level    = r_o_level;   n_o_changed = r_o_changed;
        n_o_charging = r_o_charging; n_o_points = r_o_points;
        n_o_dropped  = r_o_dropped;
        s_we    = 1'b0;
        s_waddr = r_count[AW-1:0];
        s_wdata = r_v;
        s_raddr = '0;
        s_app   = r_v;
        s_sum_p = {1'b0, r_latest} + (VOLT_W+1)'(r_rise);
        s_sum_o = {1'b0, r_prev} + (VOLT_W+1)'(r_rise);

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEARN_MODE: n_learn     = i_cfg_data[0];
                CFG_MIN_VALID:  n_min_valid = i_cfg_data[VOLT_W-1:0];
                CFG_RISE:       n_rise      = i_cfg_data[RISE_W-1:0];
                CFG_MIN_PTS:    n_min_pts   = i_cfg_data[PTS_W-1:0];
                default: ;
            endcase
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (i_cmd.op)
            OP_START: begin
                if (r_learn && !r_seen) begin
                    n_count = '0;
                end
                n_seen   = r_learn;
                n_older  = r_prev;
                n_prev   = r_latest;
                n_latest = i_voltage;
                n_v      = i_voltage;
                n_x      = r_latest;
                // history after shift: prev = r_latest, older = r_prev
                n_charging = ((r_latest != '0) && ({1'b0, i_voltage} >= s_sum_p)) ||
                             ((r_prev != '0) && (i_voltage >= r_latest) &&
                              ({1'b0, i_voltage} >= s_sum_o));
            end
            OP_EVAL: begin
                priority if (s_lt_min) begin
                    n_level = LEVEL_INVALID;
                end else if (s_use_dflt) begin
                    priority if (r_x >= DFLT_CURVE[0]) n_level = LEVEL_FULL;
                    else if (r_x <= DFLT_CURVE[DFLT_K]) n_level = LEVEL_EMPTY;
                    else begin
                        n_k   = CW'(DFLT_K);
                        n_j   = s_dj;
                        n_pre = s_dpre;
                        n_aft = s_daft;
                        n_len = CW'(1);
                    end
                end else begin
                    n_k     = r_count - CW'(3);
                    s_raddr = AW'(1);
                end
            end
            OP_C1: begin
                n_level = LEVEL_FULL;
                n_pre   = s_rd;
                s_raddr = AW'(r_count - CW'(2));
            end
            OP_CN: begin
                n_level = LEVEL_EMPTY;
                n_i     = CW'(2);
                s_raddr = AW'(2);
            end
            OP_SCAN: begin
                n_level = LEVEL_EMPTY;
                if (o_stat.scan_hit) begin
                    n_j   = r_i - CW'(2);
                    n_len = CW'(1);
                    n_aft = s_rd;
                end else begin
                    n_pre = s_rd;
                    n_i   = r_i + CW'(1);
                end
                s_raddr = AW'(r_i + CW'(1));
            end
            OP_RUN: begin
                // widen a flat run of equal points
                if (o_stat.run_more) begin
                    n_len   = r_len + CW'(1);
                    n_i     = r_i + CW'(1);
                    n_aft   = s_rd;
                    s_raddr = AW'(r_i + CW'(2));
                end
            end
            OP_M1: begin
                n_flat = (r_pre <= r_aft) || (r_x > r_pre);
                if (n_flat) begin
                    n_whole = PW'(s_kj);
                    n_part  = '0;
                end else begin
                    n_whole = PW'(s_kj) * PW'(s_span);
                    n_part  = PW'(r_pre - r_x) * PW'(r_len);
                end
            end
            OP_M2: begin
                n_level = LEVEL_EMPTY;
                n_den   = r_flat ? PW'(r_k) : PW'(r_k) * PW'(s_span);
                n_whole = r_whole - r_part;
            end
            OP_M3: begin
                n_rem   = NW'(r_whole) * NW'(LEVEL_SCALE);
                n_b     = 3'd6;
                n_level = LEVEL_EMPTY;
            end
            OP_DIV: begin
                // restoring division, one quotient bit per cycle (quotient <= 100)
                if (r_rem >= s_shift) begin
                    n_rem   = r_rem - s_shift;
                    n_level = r_level | (LEVEL_W'(1) << r_b);
                end
                n_b = r_b - 3'd1;
            end
            OP_NEXT: begin
                n_before = r_level;
                n_x      = r_v;
            end
            OP_APPEND: begin
                n_o_dropped = 1'b0;
                if (r_learn) begin
                    if (r_count < DEPTH_C) begin
                        if ((r_count != '0) && (r_last < r_v)) begin
                            s_app = r_last;
                        end
                        s_we    = 1'b1;
                        s_wdata = s_app;
                        n_last  = s_app;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_o_dropped = 1'b1;
                    end
                end
                n_out_valid  = 1'b1;
                n_o_level    = r_level;
                n_o_changed  = (r_level != r_before);
                n_o_charging = r_charging;
                n_o_points   = PTS_W'(n_count);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn     <= 1'b0;
            r_min_valid <= RST_MIN_VALID;
            r_rise      <= RST_RISE;
            r_min_pts   <= RST_MIN_PTS;
            r_seen      <= 1'b0;
            r_latest    <= '0;
            r_prev      <= '0;
            r_older     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_learn     <= n_learn;
            r_min_valid <= n_min_valid;
            r_rise      <= n_rise;
            r_min_pts   <= n_min_pts;
            r_seen      <= n_seen;
            r_latest    <= n_latest;
            r_prev      <= n_prev;
            r_older     <= n_older;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last       <= n_last;
        r_v          <= n_v;
        r_x          <= n_x;
        r_charging   <= n_charging;
        r_level      <= n_level;
        r_before     <= n_before;
        r_k          <= n_k;
        r_j          <= n_j;
        r_len        <= n_len;
        r_i          <= n_i;
        r_pre        <= n_pre;
        r_aft        <= n_aft;
        r_flat       <= n_flat;
        r_whole      <= n_whole;
        r_part       <= n_part;
        r_den        <= n_den;
        r_rem        <= n_rem;
        r_b          <= n_b;
        r_o_level    <= n_o_level;
        r_o_changed  <= n_o_changed;
        r_o_charging <= n_o_charging;
        r_o_points   <= n_o_points;
        r_o_dropped  <= n_o_dropped;
    end

    assign o_out_valid = r_out_valid;
    assign o_level     = r_o_level;
    assign o_changed   = r_o_changed;
    assign o_charging  = r_o_charging;
    assign o_points    = r_o_points;
    assign o_dropped   = r_o_dropped;
endmodule
`default_nettype wire

FILE: src/battery_level_from_voltage_curve.sv
// Battery level gauge: piecewise-linear voltage curve, default or learned.
// Work per sample: two levels, the previous and the new sample's, each interpolated unless
//   clipped; on the learned curve the work grows with the number of stored points, set by two walks over
//   the curve RAM through its single read port plus a restoring divider per level.
// Throughput: one sample at a time; a result waiting in the output register
//   does not block the next transfer until that sample's result is ready.
// Reset: synchronous active low; registers to defaults, history and point count cleared.
`default_nettype none
module battery_level_from_voltage_curve import blv_pkg::*; #(
    parameter int CURVE_DEPTH = 512
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    blv_in_if.sink     i_in,
    blv_out_if.source  o_out,
    blv_cfg_if.sink    i_cfg
);
    t_cmd  s_cmd;
    t_stat s_stat;
    logic  s_in_ready;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = s_in_ready;

    blv_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .o_in_ready(s_in_ready),
        .i_stat    (s_stat),
        .o_cmd     (s_cmd)
    );

    blv_dp #(.CURVE_DEPTH(CURVE_DEPTH)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (s_cmd),
        .o_stat     (s_stat),
        .i_voltage  (i_in.voltage_mv),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_idx  (i_cfg.index),
        .i_cfg_data (i_cfg.data),
        .i_out_ready(o_out.ready),
        .o_out_valid(o_out.valid),
        .o_level    (o_out.level_percent),
        .o_changed  (o_out.level_changed),
        .o_charging (o_out.charging),
        .o_points   (o_out.learned_points),
        .o_dropped  (o_out.learn_dropped)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && s_in_ready) |=> !s_in_ready)
        else $error("input taken while a sample is in work");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.level_percent >= LEVEL_INVALID &&
                         o_out.level_percent <= LEVEL_FULL))
        else $error("level out of range");

    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.learn_dropped) |->
            (o_out.learned_points == PTS_W'(CURVE_DEPTH)))
        else $error("sample dropped with room in the curve");

    a_start_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cmd.op == OP_START) |-> s_in_ready)
        else $error("sample started outside idle");
endmodule
`default_nettype wire
